### rtl/core/ccp_pkg.sv
// ccp_pkg: shared types and constants for the clipped coulomb potential block
// no dependencies
`default_nettype none
package ccp_pkg;
  localparam int CoordW = 17;
  localparam int SqW    = 37;   // sum of three squares, up to 3*196606^2 < 2^37
  localparam int RecW   = 32;   // reciprocal in q12, clipped to 32-bit cutoff
  localparam int ResW   = 48;
  localparam int QW     = 57;   // floor(2^56 / s)

  typedef enum logic [0:0] {
    REG_CUTOFF = 1'b0,
    REG_SHIFT  = 1'b1
  } cfg_reg_t;

  // squared distances handed from front to back
  typedef struct packed {
    logic [SqW-1:0] s0;
    logic [SqW-1:0] s1;
    logic [SqW-1:0] sp;
  } sq_item_t;
endpackage
`default_nettype wire

### rtl/core/ccp_front.sv
// ccp_front: maps coordinates and forms the three squared distances
// depends on ccp_pkg
`default_nettype none
module ccp_front import ccp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [CoordW-1:0] e0_x, e0_y, e0_z, e1_x, e1_y, e1_z,
  output logic                   sq_vld,
  output sq_item_t               sq_item
);
  logic signed [CoordW+1:0] m0x, m0y, m0z, m1x, m1y, m1z, dx, dy, dz;
  logic                     vld_r;
  sq_item_t                 item_r;

  function automatic logic [SqW-1:0] sq(input logic signed [CoordW+1:0] v);
    logic signed [2*CoordW+3:0] p;
    p = v * v;
    return p[SqW-1:0];
  endfunction

  always_comb begin
    m0x = $signed({1'b0, e0_x, 1'b0}) - 19'sd65536;
    m0y = $signed({1'b0, e0_y, 1'b0}) - 19'sd65536;
    m0z = $signed({1'b0, e0_z, 1'b0}) - 19'sd65536;
    m1x = $signed({1'b0, e1_x, 1'b0}) - 19'sd65536;
    m1y = $signed({1'b0, e1_y, 1'b0}) - 19'sd65536;
    m1z = $signed({1'b0, e1_z, 1'b0}) - 19'sd65536;
    dx  = $signed({2'b0, e1_x}) - $signed({2'b0, e0_x});
    dy  = $signed({2'b0, e1_y}) - $signed({2'b0, e0_y});
    dz  = $signed({2'b0, e1_z}) - $signed({2'b0, e0_z});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    item_r.s0 <= sq(m0x) + sq(m0y) + sq(m0z);
    item_r.s1 <= sq(m1x) + sq(m1y) + sq(m1z);
    item_r.sp <= sq(dx) + sq(dy) + sq(dz);
  end

  assign sq_vld  = vld_r;
  assign sq_item = item_r;
endmodule
`default_nettype wire

### rtl/core/ccp_queue.sv
// ccp_queue: two-entry register queue between front and back
// depends on ccp_pkg
`default_nettype none
module ccp_queue import ccp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_vld,
  input  sq_item_t      wr_item,
  output logic          rd_vld,
  output sq_item_t      rd_item
);
  // back never stalls, so the queue drains one entry per cycle
  sq_item_t mem_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_vld) wp_r <= ~wp_r;
      if (cnt_r != 2'd0) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_vld} - {1'b0, cnt_r != 2'd0};
    end
    if (wr_vld) mem_r[wp_r] <= wr_item;
  end

  assign rd_vld  = cnt_r != 2'd0;
  assign rd_item = mem_r[rp_r];
endmodule
`default_nettype wire

### rtl/core/ccp_recip.sv
// ccp_recip: pipelined clipped reciprocal square root, floor(2^28/sqrt(s))
// depends on ccp_pkg; stages: divide 57 restoring steps, then 29 isqrt steps, then the clip register
`default_nettype none
module ccp_recip import ccp_pkg::*; (
  input  wire logic            clk,
  input  wire logic [SqW-1:0]  s,
  input  wire logic [RecW-1:0] cutoff,
  output logic      [RecW-1:0] rec
);
  localparam int DivN = QW;    // quotient bits, one per stage
  localparam int SqN  = 29;    // root bits

  logic [SqW-1:0]  dv_s   [DivN+1];
  logic [SqW:0]    dv_rem [DivN+1];
  logic [QW-1:0]   dv_q   [DivN+1];
  logic            dv_z   [DivN+1];
  logic [QW+1:0]   sr_x   [SqN+1];
  logic [SqN-1:0]  sr_r   [SqN+1];
  logic            sr_z   [SqN+1];
  logic [RecW-1:0] rec_r;

  assign dv_s[0]   = s;
  assign dv_rem[0] = '0;
  assign dv_q[0]   = '0;
  assign dv_z[0]   = (s == '0);

  // dividend 2^56 has a single one at the top bit
  for (genvar i = 0; i < DivN; i++) begin : g_div
    logic [SqW:0] t;
    always_comb t = {dv_rem[i][SqW-1:0], (i == 0) ? 1'b1 : 1'b0};
    always_ff @(posedge clk) begin
      dv_s[i+1] <= dv_s[i];
      dv_z[i+1] <= dv_z[i];
      if (dv_s[i] != '0 && t >= {1'b0, dv_s[i]}) begin
        dv_rem[i+1] <= t - {1'b0, dv_s[i]};
        dv_q[i+1]   <= {dv_q[i][QW-2:0], 1'b1};
      end else begin
        dv_rem[i+1] <= t;
        dv_q[i+1]   <= {dv_q[i][QW-2:0], 1'b0};
      end
    end
  end

  assign sr_x[0] = {1'b0, dv_q[DivN]};
  assign sr_r[0] = '0;
  assign sr_z[0] = dv_z[DivN];

  // digit-by-digit root, x holds the remaining radicand
  for (genvar j = 0; j < SqN; j++) begin : g_sqrt
    localparam int B = SqN - 1 - j;
    logic [QW+1:0] trial;
    always_comb trial = ({{(QW+2-SqN){1'b0}}, sr_r[j]} << (B + 1))
                        + ((QW+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      sr_z[j+1] <= sr_z[j];
      if (sr_x[j] >= trial) begin
        sr_x[j+1] <= sr_x[j] - trial;
        sr_r[j+1] <= sr_r[j] | (SqN'(1) << B);
      end else begin
        sr_x[j+1] <= sr_x[j];
        sr_r[j+1] <= sr_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sr_z[SqN] || {3'b0, sr_r[SqN]} > cutoff) rec_r <= cutoff;
    else rec_r <= {3'b0, sr_r[SqN]};
  end

  assign rec = rec_r;
endmodule
`default_nettype wire

### rtl/core/ccp_back.sv
// ccp_back: three reciprocal pipes, weighting, shift and saturation
// depends on ccp_pkg, ccp_recip
`default_nettype none
module ccp_back import ccp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld,
  input  sq_item_t             item,
  input  wire logic [RecW-1:0] cutoff,
  input  wire logic [ResW-1:0] shift,
  output logic                 out_vld,
  output logic [ResW-1:0]      out_val
);
  localparam int Lat = QW + 29 + 1;
  logic [RecW-1:0] r0, r1, rp;
  logic [Lat-1:0]  v_r;
  logic signed [RecW+3:0]  sum_r;
  logic signed [RecW+9:0]  mul_r;
  logic signed [ResW+1:0]  tot;
  logic [2:0] v2_r;
  logic [ResW-1:0] res_r;

  ccp_recip u_r0 (.clk(clk), .s(item.s0), .cutoff(cutoff), .rec(r0));
  ccp_recip u_r1 (.clk(clk), .s(item.s1), .cutoff(cutoff), .rec(r1));
  ccp_recip u_rp (.clk(clk), .s(item.sp), .cutoff(cutoff), .rec(rp));

  always_comb
    tot = (ResW+2)'(mul_r) + (ResW+2)'($signed(shift));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      v2_r <= '0;
    end else begin
      v_r  <= {v_r[Lat-2:0], vld};
      v2_r <= {v2_r[1:0], v_r[Lat-1]};
    end
    sum_r <= $signed({4'b0, rp}) - $signed({2'b0, r0, 2'b0}) - $signed({2'b0, r1, 2'b0});
    mul_r <= (RecW+10)'(sum_r) * 42'sd30;
    if (tot > (ResW+2)'(48'sh7FFF_FFFF_FFFF)) res_r <= 48'h7FFF_FFFF_FFFF;
    else if (tot < -(ResW+2)'(49'sh0_8000_0000_0000)) res_r <= 48'h8000_0000_0000;
    else res_r <= tot[ResW-1:0];
  end

  assign out_vld = v2_r[2];
  assign out_val = res_r;
endmodule
`default_nettype wire

### rtl/core/clipped_coulomb_potential.sv
// clipped_coulomb_potential: top level, config registers, front, queue, back
// depends on ccp_pkg, ccp_front, ccp_queue, ccp_back
//
// channel  direction  handshake            payload
// in       input      start & !busy        e0_x..e1_z, 17 bits each
// out      output     out_strobe (1 cycle) potential, 48 bits signed
// cfg      input      cfg_valid & cfg_ready cfg_index, cfg_data
//
// one item per cycle; 92 register stages: 1 front + 1 queue + 87 reciprocal pipe + 3 combine
// the front loads on the accepting edge; the item then passes the queue, reciprocal pipe and combine registers
// the reciprocal pipe (57 divide steps, 29 root steps, 1 clip) sets the latency
// busy is never high; the receiver cannot stall and nothing backs up
// rst_n synchronous active low; cutoff and shift return to reset values
`default_nettype none
module clipped_coulomb_potential import ccp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CoordW-1:0] in_e0_x, in_e0_y, in_e0_z,
  input  wire logic [CoordW-1:0] in_e1_x, in_e1_y, in_e1_z,
  output logic                   out_strobe,
  output logic signed [ResW-1:0] out_potential,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [ResW-1:0]   cfg_data
);
  logic [RecW-1:0] cutoff_r;
  logic [ResW-1:0] shift_r;
  logic            acc;
  logic            sq_vld, q_vld;
  sq_item_t        sq_item, q_item;
  logic [ResW-1:0] res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start & ~busy;

  // config register transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 32'd40960;
      shift_r  <= 48'd10167873;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CUTOFF: cutoff_r <= cfg_data[RecW-1:0];
        REG_SHIFT:  shift_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  ccp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .e0_x(in_e0_x), .e0_y(in_e0_y), .e0_z(in_e0_z),
    .e1_x(in_e1_x), .e1_y(in_e1_y), .e1_z(in_e1_z),
    .sq_vld(sq_vld), .sq_item(sq_item)
  );

  ccp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_vld(sq_vld), .wr_item(sq_item),
    .rd_vld(q_vld), .rd_item(q_item)
  );

  ccp_back u_back (
    .clk(clk), .rst_n(rst_n), .vld(q_vld), .item(q_item),
    .cutoff(cutoff_r), .shift(shift_r), .out_vld(out_strobe), .out_val(res)
  );

  assign out_potential = $signed(res);

`ifndef SYNTHESIS
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  // back drains every cycle, so a queued transfer is always at the queue head next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
      sq_vld |=> q_vld)
    else $error("queued transfer lost");
`endif
endmodule
`default_nettype wire

### dv/tb.sv
// tb: self-checking bench for clipped_coulomb_potential, predicts each potential
// from the sample coordinates and compares every strobed result in order
// depends on ccp_pkg and the clipped_coulomb_potential rtl
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ccp_pkg::*;

  localparam int Latency = 92;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [CoordW-1:0] in_e0_x, in_e0_y, in_e0_z, in_e1_x, in_e1_y, in_e1_z;
  logic out_strobe;
  logic signed [ResW-1:0] out_potential;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [ResW-1:0] cfg_data;

  // local copy of the block's registers
  logic [31:0] cut_q12;
  logic signed [47:0] shift_q12;

  logic signed [ResW-1:0] pending_potentials[$];
  int errors;
  int send_idle_pct;

  clipped_coulomb_potential uut (
    .clk, .rst_n, .start, .busy,
    .in_e0_x, .in_e0_y, .in_e0_z, .in_e1_x, .in_e1_y, .in_e1_z,
    .out_strobe, .out_potential,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bit-serial integer square root, truncating
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // reciprocal distance in q12 clipped to the cutoff; coincident points give the cutoff
  function automatic logic [63:0] clipped_inv_dist(input logic [63:0] sq);
    logic [63:0] r;
    if (sq == 0) return {32'd0, cut_q12};
    r = int_sqrt((64'd1 << 56) / sq);
    if (r > {32'd0, cut_q12}) r = {32'd0, cut_q12};
    return r;
  endfunction

  function automatic logic signed [47:0] predict_potential(
      input logic [CoordW-1:0] ax, ay, az, bx, by, bz);
    logic signed [63:0] m[6];
    logic [63:0] s0, s1, sp;
    logic signed [63:0] t0, t1, tp, total;
    m[0] = 2 * $signed({47'd0, ax}) - 65536;
    m[1] = 2 * $signed({47'd0, ay}) - 65536;
    m[2] = 2 * $signed({47'd0, az}) - 65536;
    m[3] = 2 * $signed({47'd0, bx}) - 65536;
    m[4] = 2 * $signed({47'd0, by}) - 65536;
    m[5] = 2 * $signed({47'd0, bz}) - 65536;
    s0 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    s1 = m[3] * m[3] + m[4] * m[4] + m[5] * m[5];
    // pair distance in unit-cube coordinates, half the mapped difference
    sp = ((m[0] - m[3]) * (m[0] - m[3]) + (m[1] - m[4]) * (m[1] - m[4])
          + (m[2] - m[5]) * (m[2] - m[5])) / 4;
    t0 = clipped_inv_dist(s0);
    t1 = clipped_inv_dist(s1);
    tp = clipped_inv_dist(sp);
    total = 30 * (tp - 4 * (t0 + t1)) + 64'(shift_q12);
    if (total > 64'sh7FFF_FFFF_FFFF) total = 64'sh7FFF_FFFF_FFFF;
    if (total < -64'sh8000_0000_0000) total = -64'sh8000_0000_0000;
    return total[47:0];
  endfunction

  // one sample point; the predicted potential is queued on the accepting edge
  // start stays high after the transfer so items can follow back to back
  task automatic send_sample(input logic [CoordW-1:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_e0_x <= ax; in_e0_y <= ay; in_e0_z <= az;
    in_e1_x <= bx; in_e1_y <= by; in_e1_z <= bz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_potentials.push_back(predict_potential(ax, ay, az, bx, by, bz));
  endtask

  // wait for the pipe to drain, then some latency margin before touching registers
  task automatic drain();
    start <= 1'b0;
    while (pending_potentials.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [ResW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CUTOFF) cut_q12 = value[31:0];
    else shift_q12 = value;
    @(posedge clk);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CoordW'($urandom_range(131071));  // anywhere in 17 bits, often beyond the unit cube
      1: return 17'd32768;                          // on the core plane
      2: return CoordW'($urandom_range(1)) * 17'd65536;
      default: return CoordW'($urandom_range(65536));
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    send_sample(17'd32768, 17'd32768, 17'd32768, 17'd32768, 17'd32768, 17'd32768);
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(17'd65536, 17'd65536, 17'd65536, 0, 0, 0);
    send_sample(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_sample(17'h1FFFF, 0, 17'h1FFFF, 0, 17'h1FFFF, 0);
    send_sample(17'd32769, 17'd32768, 17'd32768, 17'd32768, 17'd32768, 17'd32767);
    send_sample(17'd0, 17'd32768, 17'd32768, 17'd65536, 17'd32768, 17'd32768);
    send_sample(17'd12345, 17'd54321, 17'd100, 17'd12346, 17'd54321, 17'd100);
    send_sample(17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA);
  endtask

  task automatic test_random(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    repeat (count)
      send_sample(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
  endtask

  // register extremes: saturation both ways, zero and full cutoff, then random settings and the reset values
  task automatic test_register_settings();
    write_reg(REG_CUTOFF, 48'd0);
    write_reg(REG_SHIFT, 48'h7FFF_FFFF_FFFF);
    test_directed();
    test_random(60, 0);
    drain();
    write_reg(REG_CUTOFF, 48'hFFFF_FFFF);
    write_reg(REG_SHIFT, 48'h8000_0000_0000);
    test_directed();
    test_random(60, 63);
    drain();
    write_reg(REG_SHIFT, 48'h7FFF_FFFF_FFFF);
    test_random(40, 0);
    drain();
    write_reg(REG_CUTOFF, {16'd0, 32'($urandom)});
    write_reg(REG_SHIFT, 48'({$urandom, $urandom}));
    test_random(100, 14);
    drain();
    write_reg(REG_CUTOFF, 48'd40960);
    write_reg(REG_SHIFT, 48'd10167873);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CUTOFF;
    cfg_data = '0;
    {in_e0_x, in_e0_y, in_e0_z, in_e1_x, in_e1_y, in_e1_z} = '0;
    cut_q12 = 32'd40960;
    shift_q12 = 48'sd10167873;
    errors = 0;
    send_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0);
    test_random(300, 63);
    // hold off until the pipe is empty
    drain();
    test_random(300, 14);
    drain();
    test_register_settings();
    test_random(300, 0);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // checker: compare every strobed potential against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_potentials.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, actual %0d", $time, out_potential);
      end else begin
        if (pending_potentials[0] !== out_potential) begin
          errors++;
          $display("%0t: potential mismatch, expected %0d actual %0d",
                   $time, pending_potentials[0], out_potential);
        end
        void'(pending_potentials.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
